>>> hdl/lsd_pkg.sv
// Shared constants, state types and interface structs for the shortest-digits unit.
`default_nettype none
package lsd_pkg;

    localparam int DIGIT_SLOTS = 39;
    localparam int ADDR_W      = 6;
    localparam int BIN_W       = 128;
    localparam int BCD_W       = 4 * DIGIT_SLOTS;
    localparam int CNT_W       = 7;
    localparam int EXP_W       = 6;

    localparam logic [63:0] WINDOW_LO_BITS = 64'h4350_0000_0000_0004;
    localparam logic [63:0] WINDOW_HI_BITS = 64'h47EF_FFFF_FFFF_FFF4;
    // low 7 bits of the exponent bias plus fraction width (1075)
    localparam logic [6:0]  EXP_BIAS_LOW   = 7'd51;

    typedef enum logic [1:0] {
        C_IDLE,
        C_DABBLE,
        C_SWEEP
    } t_conv_state;

    typedef enum logic [1:0] {
        E_IDLE,
        E_WRITE,
        E_SCAN,
        E_EMIT
    } t_emit_state;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        hi;
        logic [3:0]        lo;
    } t_digit_wr;

    typedef struct packed {
        logic             strobe;
        logic             last;
        logic [3:0]       digit;
        logic [EXP_W-1:0] exponent;
    } t_digit_out;

endpackage
`default_nettype wire

>>> hdl/lsd_bcd_conv.sv
// Bound formation and shift-add-3 binary to BCD conversion of both bounds.
`default_nettype none
module lsd_bcd_conv (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [63:0]       i_value_bits,
    output logic                   o_busy,
    output lsd_pkg::t_digit_wr     o_wr
);

    localparam int BCD_W = lsd_pkg::BCD_W;
    localparam int BIN_W = lsd_pkg::BIN_W;

    lsd_pkg::t_conv_state r_state, n_state;
    logic [lsd_pkg::CNT_W-1:0] r_cnt;
    logic [BIN_W-1:0] r_bin_hi, r_bin_lo;
    logic [BCD_W-1:0] r_bcd_hi, r_bcd_lo;

    logic [51:0]      frac;
    logic [6:0]       shamt;
    logic [BIN_W-1:0] v, half, step_hi, odd, low_b, high_b;
    logic [BCD_W-1:0] adj_hi, adj_lo;

    function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] x);
        logic [BCD_W-1:0] y;
        y = x;
        for (int i = 0; i < lsd_pkg::DIGIT_SLOTS; i++) begin
            if (x[4*i +: 4] >= 4'd5) begin
                y[4*i +: 4] = x[4*i +: 4] + 4'd3;
            end
        end
        return y;
    endfunction

    always_comb begin
        frac    = i_value_bits[51:0];
        shamt   = i_value_bits[58:52] - lsd_pkg::EXP_BIAS_LOW;
        v       = {{(BIN_W-53){1'b0}}, 1'b1, frac} << shamt;
        half    = {{(BIN_W-1){1'b0}}, 1'b1} << (shamt - 7'd1);
        step_hi = (frac == 52'd0) ? ({{(BIN_W-1){1'b0}}, 1'b1} << (shamt - 7'd2)) : half;
        odd     = {{(BIN_W-1){1'b0}}, i_value_bits[0]};
        low_b   = v - half + odd;
        high_b  = v + step_hi - odd;
        adj_hi  = add3(r_bcd_hi);
        adj_lo  = add3(r_bcd_lo);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsd_pkg::C_IDLE:   if (i_start) n_state = lsd_pkg::C_DABBLE;
            lsd_pkg::C_DABBLE: if (r_cnt == lsd_pkg::CNT_W'(BIN_W - 1)) n_state = lsd_pkg::C_SWEEP;
            lsd_pkg::C_SWEEP: begin
                if (r_cnt == lsd_pkg::CNT_W'(lsd_pkg::DIGIT_SLOTS - 1)) n_state = lsd_pkg::C_IDLE;
            end
            default:           n_state = lsd_pkg::C_IDLE;
        endcase
    end

    always_comb begin
        o_busy     = (r_state != lsd_pkg::C_IDLE);
        o_wr.valid = (r_state == lsd_pkg::C_SWEEP);
        o_wr.last  = (r_cnt == lsd_pkg::CNT_W'(lsd_pkg::DIGIT_SLOTS - 1));
        o_wr.addr  = r_cnt[lsd_pkg::ADDR_W-1:0];
        o_wr.hi    = r_bcd_hi[BCD_W-1 -: 4];
        o_wr.lo    = r_bcd_lo[BCD_W-1 -: 4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lsd_pkg::C_IDLE;
            r_cnt    <= '0;
            r_bin_hi <= '0;
            r_bin_lo <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                lsd_pkg::C_IDLE: begin
                    if (i_start) begin
                        r_bin_hi <= high_b;
                        r_bin_lo <= low_b;
                        r_bcd_hi <= '0;
                        r_bcd_lo <= '0;
                        r_cnt    <= '0;
                    end
                end
                lsd_pkg::C_DABBLE: begin
                    r_bcd_hi <= {adj_hi[BCD_W-2:0], r_bin_hi[BIN_W-1]};
                    r_bcd_lo <= {adj_lo[BCD_W-2:0], r_bin_lo[BIN_W-1]};
                    r_bin_hi <= r_bin_hi << 1;
                    r_bin_lo <= r_bin_lo << 1;
                    r_cnt    <= r_cnt + 1'b1;
                end
                lsd_pkg::C_SWEEP: begin
                    // advance the next most significant digit to the top
                    r_bcd_hi <= r_bcd_hi << 4;
                    r_bcd_lo <= r_bcd_lo << 4;
                    r_cnt    <= r_cnt + 1'b1;
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    a_sweep_after_dabble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == lsd_pkg::C_SWEEP)) |-> $past(r_state == lsd_pkg::C_DABBLE))
        else $error("sweep entered without conversion");
    a_sweep_starts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_state == lsd_pkg::C_SWEEP)) |-> (r_cnt == '0))
        else $error("sweep counter not cleared");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == lsd_pkg::C_IDLE) |=> (r_state == lsd_pkg::C_DABBLE))
        else $error("start not taken");

endmodule
`default_nettype wire

>>> hdl/lsd_digit_store.sv
// Digit memories with the agreement scan and the digit emission sequencer.
`default_nettype none
module lsd_digit_store (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lsd_pkg::t_digit_wr  i_wr,
    output logic                     o_busy,
    output lsd_pkg::t_digit_out      o_out
);

    localparam int AW = lsd_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(lsd_pkg::DIGIT_SLOTS - 1);

    logic [3:0] mem_hi [lsd_pkg::DIGIT_SLOTS];
    logic [3:0] mem_lo [lsd_pkg::DIGIT_SLOTS];

    lsd_pkg::t_emit_state r_state, n_state;
    logic          r_found;
    logic [AW-1:0] r_first, n_first;
    logic [AW-1:0] r_ra, r_dj, r_last_nz, r_k, end_idx;
    logic          r_dv, issue, scan_done, emit_done;
    logic [3:0]    r_rd_hi, r_rd_lo;
    logic          r_prefix, r_rzh, r_rzl;

    always_comb begin
        n_first = r_first;
        if (i_wr.valid && !r_found && i_wr.hi != 4'd0) n_first = i_wr.addr;
        end_idx   = (r_prefix || r_rzh || r_rzl) ? r_last_nz : r_k;
        scan_done = r_dv && (r_dj == LAST_ADDR);
        emit_done = r_dv && (r_dj == end_idx);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsd_pkg::E_IDLE: begin
                if (i_wr.valid) n_state = i_wr.last ? lsd_pkg::E_SCAN : lsd_pkg::E_WRITE;
            end
            lsd_pkg::E_WRITE: if (i_wr.valid && i_wr.last) n_state = lsd_pkg::E_SCAN;
            lsd_pkg::E_SCAN:  if (scan_done) n_state = lsd_pkg::E_EMIT;
            lsd_pkg::E_EMIT:  if (emit_done) n_state = lsd_pkg::E_IDLE;
            default:          n_state = lsd_pkg::E_IDLE;
        endcase
    end

    always_comb begin
        issue = ((r_state == lsd_pkg::E_SCAN) && (r_ra <= LAST_ADDR)) ||
                ((r_state == lsd_pkg::E_EMIT) && (r_ra <= end_idx));
        o_busy         = (r_state != lsd_pkg::E_IDLE);
        o_out.strobe   = (r_state == lsd_pkg::E_EMIT) && r_dv;
        o_out.last     = (r_dj == end_idx);
        o_out.digit    = r_rd_hi;
        o_out.exponent = lsd_pkg::EXP_W'(lsd_pkg::DIGIT_SLOTS) - lsd_pkg::EXP_W'(r_first);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            mem_hi[i_wr.addr] <= i_wr.hi;
            mem_lo[i_wr.addr] <= i_wr.lo;
        end
        if (issue) begin
            r_rd_hi <= mem_hi[r_ra];
            r_rd_lo <= mem_lo[r_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lsd_pkg::E_IDLE;
            r_found   <= 1'b0;
            r_first   <= '0;
            r_ra      <= '0;
            r_dv      <= 1'b0;
            r_dj      <= '0;
            r_prefix  <= 1'b1;
            r_rzh     <= 1'b1;
            r_rzl     <= 1'b1;
            r_last_nz <= '0;
            r_k       <= '0;
        end else begin
            r_state <= n_state;
            r_dv    <= issue;
            r_dj    <= r_ra;
            if (issue) r_ra <= r_ra + 1'b1;
            if (i_wr.valid) begin
                r_first <= n_first;
                if (i_wr.last) begin
                    // arm the scan at the leading digit
                    r_found   <= 1'b0;
                    r_ra      <= n_first;
                    r_prefix  <= 1'b1;
                    r_rzh     <= 1'b1;
                    r_rzl     <= 1'b1;
                    r_last_nz <= n_first;
                    r_k       <= n_first;
                end else begin
                    r_found <= r_found || (i_wr.hi != 4'd0);
                end
            end
            if (r_state == lsd_pkg::E_SCAN && r_dv && r_dj != r_first) begin
                if (r_prefix) begin
                    if (r_rd_hi == r_rd_lo) begin
                        if (r_rd_hi != 4'd0) r_last_nz <= r_dj;
                    end else begin
                        r_prefix <= 1'b0;
                        r_k      <= r_dj;
                        r_rzh    <= (r_rd_hi == 4'd0);
                        r_rzl    <= (r_rd_lo == 4'd0);
                    end
                end else begin
                    r_rzh <= r_rzh && (r_rd_hi == 4'd0);
                    r_rzl <= r_rzl && (r_rd_lo == 4'd0);
                end
            end
            if (r_state == lsd_pkg::E_SCAN && scan_done) r_ra <= r_first;
        end
    end

    a_no_write_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.valid |-> (r_state == lsd_pkg::E_IDLE || r_state == lsd_pkg::E_WRITE))
        else $error("digit write during scan or emission");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.strobe && o_out.last) |=> (r_state == lsd_pkg::E_IDLE))
        else $error("emission continued past last digit");
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.strobe |-> (r_dj >= r_first && r_dj <= end_idx && r_rd_hi <= 4'd9))
        else $error("digit emitted outside range");

endmodule
`default_nettype wire

>>> hdl/large_double_shortest_digits_unit.sv
// Top level of the shortest-digits unit for large integer-valued doubles.
//
// Usage: drive i_value_bits and raise start while busy is low; the item is
// taken at that edge. Results come back one digit per cycle on o_digit with
// o_decimal_exponent (digit count of the upper bound), each marked by o_valid
// for exactly one cycle; o_last flags the final digit. The receiver cannot
// stall, so every result must be taken in the cycle it is shown.
// A value outside the integer window gives a single result in the cycle after
// acceptance with o_out_of_range and o_last high and digit zero.
// In range, the two bounds go through a shift-add-3 conversion, a sweep
// into the digit memories, a scan over the significant digits (one memory
// read per cycle), then the digits; busy stays high the whole time.
// Reset (synchronous, active low) returns all sequencers to idle.
`default_nettype none
module large_double_shortest_digits_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_value_bits,
    output logic             o_valid,
    output logic [3:0]       o_digit,
    output logic [5:0]       o_decimal_exponent,
    output logic             o_last,
    output logic             o_out_of_range
);

    logic               accept, in_range, conv_busy, store_busy, r_oor;
    lsd_pkg::t_digit_wr  wr;
    lsd_pkg::t_digit_out dout;

    assign in_range = (i_value_bits >= lsd_pkg::WINDOW_LO_BITS) &&
                      (i_value_bits <  lsd_pkg::WINDOW_HI_BITS);
    assign busy     = conv_busy || store_busy || r_oor;
    assign accept   = start && !busy;

    lsd_bcd_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (accept && in_range),
        .i_value_bits (i_value_bits),
        .o_busy       (conv_busy),
        .o_wr         (wr)
    );

    lsd_digit_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_busy  (store_busy),
        .o_out   (dout)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oor <= 1'b0;
        end else begin
            r_oor <= accept && !in_range;
        end
    end

    always_comb begin
        o_valid            = r_oor || dout.strobe;
        o_digit            = r_oor ? 4'd0 : dout.digit;
        o_decimal_exponent = r_oor ? 6'd0 : dout.exponent;
        o_last             = r_oor || dout.last;
        o_out_of_range     = r_oor;
    end

endmodule
`default_nettype wire
